// ===== design/qte_pkg.sv =====
// Shared types, widths and constants for the quaternion to Euler angle core.
package qte_pkg;

  localparam int QW         = 16;  // quaternion component width, Q1.15
  localparam int PW         = 32;  // component product width
  localparam int RW         = 34;  // rotation term width, Q2.30 with headroom
  localparam int SW         = 62;  // square root remainder / root width
  localparam int SQRT_CELLS = 31;  // one cell per root bit, root <= 2^30
  localparam int XW         = 36;  // CORDIC x/y width (growth ~1.65)
  localparam int ZW         = 25;  // CORDIC angle width, scale 2^20
  localparam int TAB_LEN    = 24;
  localparam int LANES      = 3;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [RW-1:0] ONE_Q30   = 34'sd1073741824;
  localparam logic [SW-1:0]        ONE_Q60   = 62'h1000_0000_0000_0000;
  localparam logic signed [ZW-1:0] PI_Q20    = 25'sd3294199;
  localparam logic signed [ZW-1:0] ROUND_Q20 = 25'sd64;
  localparam int                   Q13_SHIFT = 7;
  localparam logic signed [ZW-Q13_SHIFT-1:0] ROLL_LIM  = 18'sd25736;
  localparam logic signed [ZW-Q13_SHIFT-1:0] PITCH_LIM = 18'sd12868;

  typedef struct packed {
    logic signed [RW-1:0] r11;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r31;
    logic signed [RW-1:0] r32;
    logic signed [RW-1:0] r33;
  } rterms_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef vec_t [LANES-1:0] lanes_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 25'sd823550;
      1:       a = 25'sd486170;
      2:       a = 25'sd256879;
      3:       a = 25'sd130396;
      4:       a = 25'sd65451;
      5:       a = 25'sd32757;
      6:       a = 25'sd16383;
      7:       a = 25'sd8192;
      8:       a = 25'sd4096;
      9:       a = 25'sd2048;
      10:      a = 25'sd1024;
      11:      a = 25'sd512;
      12:      a = 25'sd256;
      13:      a = 25'sd128;
      14:      a = 25'sd64;
      15:      a = 25'sd32;
      16:      a = 25'sd16;
      17:      a = 25'sd8;
      18:      a = 25'sd4;
      19:      a = 25'sd2;
      20:      a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/qte_front.sv =====
// Front end: component products, rotation terms, clamp and one minus the square of R31.
module qte_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [qte_pkg::QW-1:0] w_i,
  input  logic signed [qte_pkg::QW-1:0] x_i,
  input  logic signed [qte_pkg::QW-1:0] y_i,
  input  logic signed [qte_pkg::QW-1:0] z_i,
  output logic                      valid_o,
  output qte_pkg::rterms_t          terms_o,
  output logic [qte_pkg::SW-1:0]    rad_o
);

  localparam int PW = qte_pkg::PW;
  localparam int RW = qte_pkg::RW;
  localparam int SW = qte_pkg::SW;

  logic v1_q, v2_q, v3_q;
  logic signed [PW-1:0] ww_q, xx_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  qte_pkg::rterms_t t2_d, t2_q, t3_q;
  logic signed [RW-1:0] r31_raw;
  logic signed [30:0] s31;
  logic signed [SW-1:0] sq;
  logic [SW-1:0] rad_d, rad_q;

  always_comb begin
    t2_d.r11 = ((RW'(ww_q) + RW'(xx_q)) <<< 1) - qte_pkg::ONE_Q30;
    t2_d.r21 = (RW'(xy_q) - RW'(wz_q)) <<< 1;
    r31_raw  = (RW'(xz_q) + RW'(wy_q)) <<< 1;
    t2_d.r32 = (RW'(yz_q) - RW'(wx_q)) <<< 1;
    t2_d.r33 = ((RW'(ww_q) + RW'(zz_q)) <<< 1) - qte_pkg::ONE_Q30;
    if (r31_raw > qte_pkg::ONE_Q30) begin
      t2_d.r31 = qte_pkg::ONE_Q30;
    end else if (r31_raw < -qte_pkg::ONE_Q30) begin
      t2_d.r31 = -qte_pkg::ONE_Q30;
    end else begin
      t2_d.r31 = r31_raw;
    end
  end

  // clamped R31 is within +-2^30 (+2^30 wraps to -2^30 in 31 bits); its square is at most 2^60
  assign s31   = t2_q.r31[30:0];
  assign sq    = s31 * s31;
  assign rad_d = qte_pkg::ONE_Q60 - SW'(sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q  <= w_i * w_i;
      xx_q  <= x_i * x_i;
      zz_q  <= z_i * z_i;
      xy_q  <= x_i * y_i;
      wz_q  <= w_i * z_i;
      xz_q  <= x_i * z_i;
      wy_q  <= w_i * y_i;
      yz_q  <= y_i * z_i;
      wx_q  <= w_i * x_i;
      t2_q  <= t2_d;
      t3_q  <= t2_q;
      rad_q <= rad_d;
    end
  end

  assign valid_o = v3_q;
  assign terms_o = t3_q;
  assign rad_o   = rad_q;

endmodule

// ===== design/qte_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root; carries the rotation terms.
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qte_pkg::sqrt_t   s_i,
  input  qte_pkg::rterms_t t_i,
  output logic             valid_o,
  output qte_pkg::sqrt_t   s_o,
  output qte_pkg::rterms_t t_o
);

  localparam int SW = qte_pkg::SW;
  localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

  logic             v_q;
  qte_pkg::sqrt_t   s_d, s_q;
  qte_pkg::rterms_t t_q;
  logic [SW-1:0]    trial;

  always_comb begin
    trial = s_i.root + BIT;
    if (s_i.rem >= trial) begin
      s_d.rem  = s_i.rem - trial;
      s_d.root = (s_i.root >> 1) + BIT;
    end else begin
      s_d.rem  = s_i.rem;
      s_d.root = s_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
      t_q <= t_i;
    end
  end

  assign valid_o = v_q;
  assign s_o     = s_q;
  assign t_o     = t_q;

endmodule

// ===== design/qte_cordic_cell.sv =====
// One CORDIC vectoring iteration for all three angle lanes.
module qte_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qte_pkg::lanes_t l_i,
  output logic            valid_o,
  output qte_pkg::lanes_t l_o
);

  localparam int XW = qte_pkg::XW;
  localparam int ZW = qte_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = qte_pkg::atan_q20(SHIFT);

  logic            v_q;
  qte_pkg::lanes_t l_d, l_q;
  logic signed [XW-1:0] xv, yv, xs, ys;

  always_comb begin
    for (int n = 0; n < qte_pkg::LANES; n++) begin
      xv = l_i[n].x;
      yv = l_i[n].y;
      xs = xv >>> SHIFT;
      ys = yv >>> SHIFT;
      l_d[n].zero = l_i[n].zero;
      if (!yv[XW-1]) begin
        l_d[n].x = xv + ys;
        l_d[n].y = yv - xs;
        l_d[n].z = l_i[n].z + ATAN;
      end else begin
        l_d[n].x = xv - ys;
        l_d[n].y = yv + xs;
        l_d[n].z = l_i[n].z - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= l_d;
    end
  end

  assign valid_o = v_q;
  assign l_o     = l_q;

endmodule

// ===== design/quaternion_to_euler_angles_core.sv =====
// Top level: quaternion (Q1.15) to ZYX Euler angles (Q3.13, pitch Q2.13) pipeline.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+------------------------------------------
//   in      | in_valid_i | in_ready_o  | quat_w_i, quat_x_i, quat_y_i, quat_z_i
//   out     | out_valid_o| out_ready_i | roll_angle_o, pitch_angle_o, yaw_angle_o
//
// One transfer per cycle while the skid entry is empty. The pipeline is three front
// stages, one cell per square root bit, one cell per CORDIC iteration (min(CORDIC_STAGES,
// 24) cells), then the output register. Reset clears only valid bits.
// A two-entry output (register plus skid) lets the pipeline take one more transfer
// while a result waits; the whole pipeline holds while the skid entry is full.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qte_pkg::QW-1:0]       quat_w_i,
  input  logic signed [qte_pkg::QW-1:0]       quat_x_i,
  input  logic signed [qte_pkg::QW-1:0]       quat_y_i,
  input  logic signed [qte_pkg::QW-1:0]       quat_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qte_pkg::ROLL_W-1:0]   roll_angle_o,
  output logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle_o,
  output logic signed [qte_pkg::ROLL_W-1:0]   yaw_angle_o
);

  localparam int NSTG = (CORDIC_STAGES < qte_pkg::TAB_LEN) ? CORDIC_STAGES
                                                          : qte_pkg::TAB_LEN;
  localparam int NSQ = qte_pkg::SQRT_CELLS;
  localparam int XW  = qte_pkg::XW;
  localparam int ZW  = qte_pkg::ZW;
  localparam int RW  = qte_pkg::RW;
  localparam int AW  = ZW - qte_pkg::Q13_SHIFT;

  logic en;
  logic ov_q, sv_q;

  logic                front_v;
  qte_pkg::rterms_t    front_t;
  logic [qte_pkg::SW-1:0] front_rad;

  logic             sq_v [NSQ+1];
  qte_pkg::sqrt_t   sq_s [NSQ+1];
  qte_pkg::rterms_t sq_t [NSQ+1];

  logic            cc_v [NSTG+1];
  qte_pkg::lanes_t cc_l [NSTG+1];

  logic signed [XW-1:0] ay [qte_pkg::LANES];
  logic signed [XW-1:0] ax [qte_pkg::LANES];

  logic signed [ZW-1:0] zf [qte_pkg::LANES];
  logic signed [AW-1:0] ang [qte_pkg::LANES];
  logic signed [AW-1:0] lim;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_d, yaw_d, roll_q, yaw_q, sroll_q, syaw_q;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_d, pitch_q, spitch_q;

  assign en         = !sv_q;
  assign in_ready_o = en;

  qte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .w_i     (quat_w_i),
    .x_i     (quat_x_i),
    .y_i     (quat_y_i),
    .z_i     (quat_z_i),
    .valid_o (front_v),
    .terms_o (front_t),
    .rad_o   (front_rad)
  );

  assign sq_v[0]      = front_v;
  assign sq_s[0].rem  = front_rad;
  assign sq_s[0].root = '0;
  assign sq_t[0]      = front_t;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[j]),
      .s_i     (sq_s[j]),
      .t_i     (sq_t[j]),
      .valid_o (sq_v[j+1]),
      .s_o     (sq_s[j+1]),
      .t_o     (sq_t[j+1])
    );
  end

  // vector set-up: half-plane fold and the both-zero case
  always_comb begin
    ay[qte_pkg::LANE_ROLL]  = XW'(sq_t[NSQ].r32);
    ax[qte_pkg::LANE_ROLL]  = XW'(sq_t[NSQ].r33);
    ay[qte_pkg::LANE_PITCH] = XW'(sq_t[NSQ].r31);
    ax[qte_pkg::LANE_PITCH] = $signed({{(XW-RW){1'b0}}, sq_s[NSQ].root[RW-1:0]});
    ay[qte_pkg::LANE_YAW]   = XW'(sq_t[NSQ].r21);
    ax[qte_pkg::LANE_YAW]   = XW'(sq_t[NSQ].r11);
    for (int n = 0; n < qte_pkg::LANES; n++) begin
      cc_l[0][n].zero = (ax[n] == '0) && (ay[n] == '0);
      if (ax[n][XW-1]) begin
        cc_l[0][n].x = -ax[n];
        cc_l[0][n].y = -ay[n];
        cc_l[0][n].z = ay[n][XW-1] ? -qte_pkg::PI_Q20 : qte_pkg::PI_Q20;
      end else begin
        cc_l[0][n].x = ax[n];
        cc_l[0][n].y = ay[n];
        cc_l[0][n].z = '0;
      end
    end
  end
  assign cc_v[0] = sq_v[NSQ];

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    qte_cordic_cell #(.SHIFT(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cc_v[i]),
      .l_i     (cc_l[i]),
      .valid_o (cc_v[i+1]),
      .l_o     (cc_l[i+1])
    );
  end

  // Q20 -> Q3.13 with rounding, then saturate; pitch is negated and saturates to +-pi/2
  always_comb begin
    for (int n = 0; n < qte_pkg::LANES; n++) begin
      if (cc_l[NSTG][n].zero) begin
        zf[n] = '0;
      end else if (n == qte_pkg::LANE_PITCH) begin
        zf[n] = -cc_l[NSTG][n].z;
      end else begin
        zf[n] = cc_l[NSTG][n].z;
      end
      zf[n]  = zf[n] + qte_pkg::ROUND_Q20;
      ang[n] = zf[n][ZW-1:qte_pkg::Q13_SHIFT];
      lim    = (n == qte_pkg::LANE_PITCH) ? qte_pkg::PITCH_LIM : qte_pkg::ROLL_LIM;
      if (ang[n] > lim) begin
        ang[n] = lim;
      end else if (ang[n] < -lim) begin
        ang[n] = -lim;
      end
    end
    roll_d  = ang[qte_pkg::LANE_ROLL][qte_pkg::ROLL_W-1:0];
    pitch_d = ang[qte_pkg::LANE_PITCH][qte_pkg::PITCH_W-1:0];
    yaw_d   = ang[qte_pkg::LANE_YAW][qte_pkg::ROLL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (out_ready_i || !ov_q) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= cc_v[NSTG];
      end
    end else if (en && cc_v[NSTG]) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !ov_q) begin
      if (sv_q) begin
        roll_q  <= sroll_q;
        pitch_q <= spitch_q;
        yaw_q   <= syaw_q;
      end else begin
        roll_q  <= roll_d;
        pitch_q <= pitch_d;
        yaw_q   <= yaw_d;
      end
    end else if (en && cc_v[NSTG]) begin
      sroll_q  <= roll_d;
      spitch_q <= pitch_d;
      syaw_q   <= yaw_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule
